// File: hdl/mbs_pkg.sv
package mbs_pkg;

  localparam int MAX_BOUNDARY_CHARS = 32;
  localparam int LEAD_LEN           = 4;
  localparam int WINDOW_DEPTH       = MAX_BOUNDARY_CHARS + LEAD_LEN;
  localparam int CNT_W              = $clog2(WINDOW_DEPTH + 1);
  localparam int CHAR_REGS          = 4;
  localparam int CHARS_W            = 64 * CHAR_REGS;
  localparam int LEN_W              = 6;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_IDX_W          = 3;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNDARY_LENGTH = 3'd0,
    REG_BOUNDARY_CHARS0 = 3'd1,
    REG_BOUNDARY_CHARS1 = 3'd2,
    REG_BOUNDARY_CHARS2 = 3'd3,
    REG_BOUNDARY_CHARS3 = 3'd4
  } reg_idx_t;

  typedef logic [WINDOW_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len_code;
    logic [CHARS_W-1:0] chars;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic             skipping;
    logic [CNT_W-1:0] held_count;
    logic [CNT_W-1:0] delim_len;
  } stat_t;

endpackage

// File: hdl/mbs_matcher.sv
module mbs_matcher
  import mbs_pkg::*;
(
  input  win_t               window,
  input  logic [CNT_W-1:0]   delim_len,
  input  logic [CHARS_W-1:0] chars,
  output logic               match
);

  logic [WINDOW_DEPTH-1:0][7:0] pattern;
  logic [WINDOW_DEPTH-1:0]      hit;

  // delimiter = CR LF '-' '-' + boundary chars; entries past delim_len don't care
  always_comb begin
    pattern[0] = CHAR_CR;
    pattern[1] = CHAR_LF;
    pattern[2] = CHAR_DASH;
    pattern[3] = CHAR_DASH;
    for (int i = LEAD_LEN; i < WINDOW_DEPTH; i++) begin
      pattern[i] = chars[8*(i-LEAD_LEN) +: 8];
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      hit[i] = (window[i] == pattern[i]) || (CNT_W'(i) >= delim_len);
    end
    match = &hit;
  end

endmodule

// File: hdl/mbs_core.sv
module mbs_core
  import mbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       restart,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  cfg_t       cfg,
  output res_t       res,
  output stat_t      stat
);

  win_t             win_r, win_nxt, win_wr;
  logic [CNT_W-1:0] held_count_r, held_count_nxt;
  logic             skipping_r, skipping_nxt;
  logic [1:0]       progress_r, progress_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] delim_len;
  logic             pass_thru;
  logic             full;
  logic             match;
  logic [7:0]       blank_exp;

  assign pass_thru = (cfg.len_code == '0);
  assign eff_len   = (cfg.len_code > LEN_W'(MAX_BOUNDARY_CHARS))
                     ? LEN_W'(MAX_BOUNDARY_CHARS) : cfg.len_code;
  assign delim_len = CNT_W'(eff_len) + CNT_W'(LEAD_LEN);
  assign full      = (CNT_W'(held_count_r + CNT_W'(1)) == delim_len);
  assign blank_exp = progress_r[0] ? CHAR_LF : CHAR_CR;

  // window with the new byte dropped in at the fill point
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_wr[i] = (held_count_r == CNT_W'(i)) ? in_byte : win_r[i];
    end
  end

  mbs_matcher u_matcher (
    .window    (win_wr),
    .delim_len (delim_len),
    .chars     (cfg.chars),
    .match     (match)
  );

  always_comb begin
    win_nxt        = win_r;
    held_count_nxt = held_count_r;
    skipping_nxt   = skipping_r;
    progress_nxt   = progress_r;
    res            = '0;
    if (pass_thru) begin
      res = '{valid: 1'b1, data: in_byte};
    end else if (skipping_r) begin
      if (in_byte == blank_exp) begin
        progress_nxt = progress_r + 2'd1;
        if (progress_r == 2'd3) begin
          skipping_nxt = 1'b0;
        end
      end else begin
        progress_nxt = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end else if (!full) begin
      win_nxt        = win_wr;
      held_count_nxt = held_count_r + CNT_W'(1);
    end else if (match) begin
      held_count_nxt = '0;
      skipping_nxt   = 1'b1;
      progress_nxt   = 2'd0;
    end else begin
      // release oldest byte, slide the rest down; count stays at len-1
      res = '{valid: 1'b1, data: win_wr[0]};
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_nxt[i] = win_wr[i+1];
      end
      win_nxt[WINDOW_DEPTH-1] = win_wr[WINDOW_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      held_count_r <= CNT_W'(2);
      skipping_r   <= 1'b0;
      progress_r   <= 2'd0;
    end else if (step) begin
      held_count_r <= held_count_nxt;
      skipping_r   <= skipping_nxt;
      progress_r   <= progress_nxt;
    end
  end

  // only the CR LF seed is reset; the rest is written before it is compared
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r[0] <= CHAR_CR;
      win_r[1] <= CHAR_LF;
    end else if (step) begin
      win_r <= win_nxt;
    end
  end

  assign stat = '{skipping: skipping_r, held_count: held_count_r, delim_len: delim_len};

endmodule

// File: hdl/multipart_boundary_stripper.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_byte[7:0]
// out_      output     out_valid/out_ready  out_byte[7:0]
// cfg_      input      cfg_we (no wait)     cfg_index[2:0], cfg_data[63:0]
//
// One byte per cycle sustained while out_ready is high; out_valid is registered.
// Input register -> strip step (window update + parallel delimiter compare) ->
// output register. Synchronous active-low reset; no clearing pass needed.
// Output stall holds the output register; the input register drains into it
// in the same cycle it is taken, so in_ready only drops while both are full
// and out_ready is low.
module multipart_boundary_stripper
  import mbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [LEN_W-1:0]   len_code_r;
  logic [CHARS_W-1:0] chars_r;
  logic               restart;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       advance;

  // output stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;

  res_t  res;
  stat_t stat;
  cfg_t  cfg;

  // a boundary_length write restarts the parser
  assign restart = cfg_we && (cfg_index == REG_BOUNDARY_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_code_r <= '0;
      chars_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOUNDARY_LENGTH: len_code_r <= cfg_data[LEN_W-1:0];
        REG_BOUNDARY_CHARS0: chars_r[0*64 +: 64] <= cfg_data;
        REG_BOUNDARY_CHARS1: chars_r[1*64 +: 64] <= cfg_data;
        REG_BOUNDARY_CHARS2: chars_r[2*64 +: 64] <= cfg_data;
        REG_BOUNDARY_CHARS3: chars_r[3*64 +: 64] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{len_code: len_code_r, chars: chars_r};

  // the held byte moves on whenever the output register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  mbs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .step    (advance),
    .in_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res),
    .stat    (stat)
  );

  // result register: loaded by a step, cleared when taken
  always_comb begin
    if (advance) begin
      out_valid_nxt = res.valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // pass-through: every step yields a transaction
  a_pass_thru: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (len_code_r == '0)) |=> out_valid_r)
    else $error("pass-through step gave no result");

  // header skipping never releases a byte
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stat.skipping && (len_code_r != '0)) |=> !out_valid_r)
    else $error("byte released while skipping a part header");

  // window fill never reaches the delimiter length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_code_r != '0) |-> (stat.held_count < stat.delim_len))
    else $error("held count out of range");

  // a restart puts the parser back to its start state
  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (restart && !s1_valid_r) |=> (stat.held_count == CNT_W'(2)) && !stat.skipping)
    else $error("restart did not reinitialize the parser");

endmodule

// File: tb/sv/mbs_body_checker.sv
`timescale 1ns / 100ps

module mbs_body_checker
  import mbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    bytes_in,
  output int                    bytes_out,
  output int                    delims_stripped
);

  localparam int REPORT_LIMIT = 10;

  // shadow of the configuration and of the parser state
  logic [LEN_W-1:0] len_code;
  logic [63:0]      char_reg [CHAR_REGS];
  logic [7:0]       window [WINDOW_DEPTH];
  int unsigned      held;
  logic             skipping;
  int unsigned      blank_seen;

  // body bytes that the block still owes us, oldest first
  logic [7:0]       body_bytes_q [$];

  function automatic logic [7:0] delim_at(input int unsigned k);
    int unsigned c;
    if (k == 0) return CHAR_CR;
    if (k == 1) return CHAR_LF;
    if (k < LEAD_LEN) return CHAR_DASH;
    c = k - LEAD_LEN;
    return char_reg[c / 8][8 * (c % 8) +: 8];
  endfunction

  function automatic int unsigned delim_total();
    int unsigned n;
    n = len_code;
    if (n > MAX_BOUNDARY_CHARS) n = MAX_BOUNDARY_CHARS;
    return n + LEAD_LEN;
  endfunction

  task automatic restart_parser();
    foreach (window[i]) window[i] = 8'h00;
    window[0]  = CHAR_CR;
    window[1]  = CHAR_LF;
    held       = 2;
    skipping   = 1'b0;
    blank_seen = 0;
  endtask

  task automatic strip_byte(input logic [7:0] b, output logic released, output logic [7:0] rel);
    int unsigned len;
    logic        hit;
    released = 1'b0;
    rel      = 8'h00;
    if (len_code == '0) begin
      released = 1'b1;
      rel      = b;
      return;
    end
    if (skipping) begin
      // looking for CR LF CR LF; even positions want CR
      if (b == ((blank_seen % 2 == 0) ? CHAR_CR : CHAR_LF)) begin
        blank_seen++;
        if (blank_seen >= 4) begin
          blank_seen = 0;
          skipping   = 1'b0;
        end
      end else begin
        blank_seen = (b == CHAR_CR) ? 1 : 0;
      end
      return;
    end
    len = delim_total();
    if (held + 1 < len) begin
      window[held] = b;
      held++;
      return;
    end
    window[len-1] = b;
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (window[i] != delim_at(i)) hit = 1'b0;
    end
    if (hit) begin
      held       = 0;
      skipping   = 1'b1;
      blank_seen = 0;
      delims_stripped++;
      return;
    end
    released = 1'b1;
    rel      = window[0];
    for (int i = 0; i + 1 < len; i++) window[i] = window[i+1];
    held = len - 1;
  endtask

  always @(posedge clk) begin : monitor
    logic       rel_valid;
    logic [7:0] rel;
    logic [7:0] want;
    if (!rst_n) begin
      len_code = '0;
      foreach (char_reg[i]) char_reg[i] = '0;
      restart_parser();
      body_bytes_q.delete();
      mismatches      = 0;
      bytes_in        = 0;
      bytes_out       = 0;
      delims_stripped = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BOUNDARY_LENGTH: begin
            len_code = cfg_data[LEN_W-1:0];
            restart_parser();
          end
          REG_BOUNDARY_CHARS0: char_reg[0] = cfg_data;
          REG_BOUNDARY_CHARS1: char_reg[1] = cfg_data;
          REG_BOUNDARY_CHARS2: char_reg[2] = cfg_data;
          REG_BOUNDARY_CHARS3: char_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        bytes_out++;
        if (body_bytes_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: out_byte 0x%02h arrived with nothing expected", $time, out_byte);
          mismatches++;
        end else begin
          want = body_bytes_q.pop_front();
          if (out_byte !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: out_byte expected 0x%02h, got 0x%02h", $time, want, out_byte);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        strip_byte(in_byte, rel_valid, rel);
        if (rel_valid) body_bytes_q.push_back(rel);
      end
    end
    pending = body_bytes_q.size();
  end

endmodule

// File: tb/sv/tb_multipart_boundary_stripper.sv
`timescale 1ns / 100ps

module tb_multipart_boundary_stripper;
  import mbs_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 10;
  // pipeline is two deep; give bytes that release nothing time to leave
  localparam int SETTLE_CYCLES = 8;
  // long output stall, well beyond what the block can absorb
  localparam int HOLD_CYCLES   = 300;
  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEM_GOAL     = 900;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  cfg_we;
  reg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int bytes_in;
  int bytes_out;
  int delims_stripped;

  // what the stimulus side believes is configured; used to build delimiters
  logic [LEN_W-1:0] cur_len;
  logic [63:0]      cur_chars [CHAR_REGS];

  int sent_total;
  int phases_run;
  int idle_cycles;
  bit tx_burst;
  bit rx_burst;
  bit hold_request;

  multipart_boundary_stripper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbs_body_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .bytes_in        (bytes_in),
    .bytes_out       (bytes_out),
    .delims_stripped (delims_stripped)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: any transaction or register write resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side. Random stall before each transaction, occasional bursts with
  // ready held high, and one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    rx_burst  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input transaction, preceded by a random gap. Valid is raised without
  // looking at ready and held with the same byte until taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
    sent_total++;
  endtask

  // Stop sending and wait until every expected body byte has come out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Character registers first (random or one fill word), then the length,
  // whose write also restarts the parser.
  task automatic configure(input logic [CFG_DATA_W-1:0] len_word, input logic [63:0] fill,
                           input bit random_chars);
    for (int r = 0; r < CHAR_REGS; r++) begin
      cur_chars[r] = random_chars ? {$urandom(), $urandom()} : fill;
      write_reg(reg_idx_t'(REG_BOUNDARY_CHARS0 + r), cur_chars[r]);
    end
    cur_len = len_word[LEN_W-1:0];
    write_reg(REG_BOUNDARY_LENGTH, len_word);
  endtask

  // Full delimiter length as the block sees it; codes above the maximum clamp.
  function automatic int delim_len();
    int n;
    n = (cur_len > MAX_BOUNDARY_CHARS) ? MAX_BOUNDARY_CHARS : cur_len;
    return n + LEAD_LEN;
  endfunction

  function automatic logic [7:0] delim_byte(input int k);
    if (k == 0) return CHAR_CR;
    if (k == 1) return CHAR_LF;
    if (k < LEAD_LEN) return CHAR_DASH;
    return cur_chars[(k - LEAD_LEN) / 8][8 * ((k - LEAD_LEN) % 8) +: 8];
  endfunction

  // Delimiter bytes first..last-1; spoil flips a bit in the final byte so
  // the window almost matches and must then release its oldest byte.
  task automatic send_delim(input int first, input int last, input bit spoil);
    logic [7:0] b;
    for (int k = first; k < last; k++) begin
      b = delim_byte(k);
      if (spoil && k == last - 1) b = b ^ 8'h20;
      send_byte(b);
    end
  endtask

  task automatic send_blank();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // Part header: printable text with stray CR, LF and zero bytes, which break
  // or restart the blank-line search, closed by the blank line.
  task automatic send_header();
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, 10);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       b = CHAR_CR;
        1:       b = CHAR_LF;
        2:       b = 8'h00;
        default: b = 8'($urandom_range(32, 126));
      endcase
      send_byte(b);
    end
    send_blank();
  endtask

  // Part body: random bytes salted with near-misses of the delimiter.
  task automatic send_body();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
    repeat (n) begin
      case ($urandom_range(0, 19))
        12:      send_byte(CHAR_CR);
        13:      send_byte(CHAR_LF);
        14:      send_byte(CHAR_DASH);
        15, 16:  send_delim(0, $urandom_range(1, delim_len() - 1), 1'b0);
        17:      send_delim(0, delim_len(), 1'b1);
        18:      send_blank();
        19: begin
          send_byte(CHAR_DASH);
          send_byte(CHAR_DASH);
        end
        default: send_byte(8'($urandom()));
      endcase
    end
  endtask

  // A multipart stream of roughly budget bytes. It opens either with a
  // preamble or right at a delimiter (leading CR LF left out, since the
  // window starts out holding it), then parts, then either the closing
  // delimiter with a trailer that must vanish or a part cut off mid-body.
  task automatic send_multipart(input int budget);
    int start;
    start = sent_total;
    if ($urandom_range(0, 2) == 0) begin
      send_body();
      send_delim(0, delim_len(), 1'b0);
    end else begin
      send_delim(2, delim_len(), 1'b0);
    end
    while (sent_total - start < budget) begin
      send_header();
      send_body();
      if ($urandom_range(0, 9) == 0) begin
        // broken part: header never ends, so the next delimiter is swallowed
        send_delim(0, delim_len(), 1'b0);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(32, 126)));
      end
      send_delim(0, delim_len(), 1'b0);
    end
    if ($urandom_range(0, 2) == 0) begin
      send_byte(CHAR_DASH);
      send_byte(CHAR_DASH);
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(32, 126)));
    end else begin
      send_header();
      send_body();
    end
  endtask

  initial begin : stimulus
    int budget;
    int phase_kind;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = REG_BOUNDARY_LENGTH;
    cfg_data     = '0;
    cur_len      = '0;
    foreach (cur_chars[i]) cur_chars[i] = '0;
    tx_burst     = 1'b0;
    hold_request = 1'b0;
    sent_total   = 0;
    phases_run   = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed: pass-through out of reset with the byte extremes and the
    // delimiter lead characters.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_DASH);
    drain();

    // One-character boundary "x": delimiter at the very start of the stream,
    // a header where a second CR breaks the blank-line match and a zero byte
    // sits inside, then a body with a near-miss of the delimiter.
    configure(64'd1, 64'h78, 1'b0);
    send_byte(CHAR_DASH);
    send_byte(CHAR_DASH);
    send_byte(8'h78);
    send_byte(8'h68);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(8'h00);
    send_blank();
    send_byte(8'h41);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_DASH);
    send_byte(8'h51);

    // Random phases, each under its own boundary setting. Every phase starts
    // with the input idle and all results collected.
    while (sent_total < ITEM_GOAL) begin
      drain();
      budget     = $urandom_range(70, 120);
      phase_kind = phases_run % 8;
      case (phase_kind)
        0: configure(64'd1, '0, 1'b1);
        1: begin
          // longest boundary; stall the output so the block backs up
          configure(64'd32, '0, 1'b1);
          hold_request = 1'b1;
        end
        // top length code, junk in the upper data bits, all-ones characters
        2: configure({$urandom(), $urandom()} | 64'h3F, '1, 1'b0);
        3: configure(64'd0, '0, 1'b1);
        4: configure(64'($urandom_range(1, 31)), '0, 1'b0);
        5: configure(64'($urandom_range(1, 8)), '0, 1'b1);
        6: configure(64'($urandom_range(33, 62)), '0, 1'b1);
        default: configure(64'($urandom_range(1, 63)), '0, 1'b1);
      endcase
      if (phase_kind == 5) begin
        // new characters mid-stream, parser state left as it is
        send_multipart(budget / 2);
        drain();
        cur_chars[0] = {$urandom(), $urandom()};
        write_reg(REG_BOUNDARY_CHARS0, cur_chars[0]);
        send_multipart(budget / 2);
      end else begin
        send_multipart(budget);
      end
      phases_run++;
    end
    drain();

    $display("Run: %0d bytes in over %0d boundary settings (lengths 0 to 63)",
             bytes_in, phases_run + 2);
    $display("Run: %0d bytes out, %0d delimiters stripped, 0-7 cycle gaps, %0d-cycle hold-off",
             bytes_out, delims_stripped, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mbs_pkg.sv
hdl/mbs_matcher.sv
hdl/mbs_core.sv
hdl/multipart_boundary_stripper.sv
tb/sv/mbs_body_checker.sv
tb/sv/tb_multipart_boundary_stripper.sv
